// ----- rtl/wrrs_pkg.sv -----
// Package for the weighted round-robin scheduler: function codes, status codes
// and the score-to-slice bucketing. No dependencies.
`timescale 1ns / 1ps

package wrrs_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int SLICE_W  = 4;
    localparam int TID_W    = 5;

    localparam logic [FUNC_W-1:0] FUNC_ENQ   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_YIELD = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PICK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_SLICE_MIN = 1'b0;
    localparam logic CFG_SLICE_MAX = 1'b1;

    // Request to the divider and its answer.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    // Slice for a quotient magnitude q, negative when neg is set.
    function automatic logic [SLICE_W-1:0] slice_of(input logic neg,
                                                    input logic [63:0] q);
        logic [3:0] sc;
        begin
            if (q == 64'd0) begin
                sc = 4'd0;
            end else if (neg) begin
                if (q > 64'd9)      sc = 4'd1;
                else if (q > 64'd4) sc = 4'd2;
                else if (q > 64'd2) sc = 4'd3;
                else                sc = 4'd5;
            end else begin
                if (q == 64'd1)     sc = 4'd5;
                else if (q < 64'd4) sc = 4'd7;
                else if (q < 64'd9) sc = 4'd8;
                else                sc = 4'd9;
            end
            slice_of = 4'd10 - sc;
        end
    endfunction

endpackage

// ----- rtl/weight_ratio_round_robin_scheduler_top.sv -----
// Top level of the weighted round-robin scheduler: run queue storage,
// sequencer and result register. Depends on wrrs_pkg and wrrs_div.
`timescale 1ns / 1ps

// One request at a time. An unused function code or an out-of-range task id
// goes straight to S_OUT; pick passes through S_READ and S_UNLINK, and dequeue,
// yield or an unexpired tick through S_LINK as well. Enqueue and an expiring
// tick recompute the slice on one shared bit-serial divider of WEIGHT_BITS+5
// bits, first the average weight and then the weight ratio. A zero weight or
// a zero average skips the second division, and an expiring tick on an empty
// queue needs none. s_ready is low while a request is in work or a result
// waits, so the next request is taken in the cycle after the result is
// accepted at the earliest. Link, slice and weight tables need no clearing
// pass after reset.
module weight_ratio_round_robin_scheduler_top #(
    parameter int MAX_TASKS   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [wrrs_pkg::FUNC_W-1:0]    s_func,
    input  logic [wrrs_pkg::TID_W-1:0]     s_task_id,
    input  logic [15:0]                    s_weight,
    input  logic                           s_at_head,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [wrrs_pkg::TID_W-1:0]     m_picked_task,
    output logic                           m_picked_valid,
    output logic [wrrs_pkg::SLICE_W-1:0]   m_slice_out,
    output logic                           m_need_resched,
    output logic [wrrs_pkg::STATUS_W-1:0]  m_status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [3:0]                     cfg_data
);
    import wrrs_pkg::*;

    localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int TOT_W   = WEIGHT_BITS + 5;
    localparam int DIV_W   = TOT_W;
    localparam int W_USE   = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_UNLINK, S_LINK, S_DIV1, S_DIV2, S_SLICE, S_OUT
    } state_t;

    state_t state_reg;

    logic [IDX_W-1:0]       nxt_mem [MAX_TASKS];
    logic [IDX_W-1:0]       prv_mem [MAX_TASKS];
    logic [SLICE_W-1:0]     slc_mem [MAX_TASKS];
    logic [WEIGHT_BITS-1:0] lw_mem  [MAX_TASKS];
    logic [MAX_TASKS-1:0]   inq_reg;
    logic [IDX_W-1:0]       head_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [3:0]             smin_reg, smax_reg;

    logic [FUNC_W-1:0]      func_reg;
    logic [IDX_W-1:0]       tid_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic                   ath_reg, tick_exp_reg, relink_reg;
    logic [SLICE_W-1:0]     slc_reg;
    logic [WEIGHT_BITS-1:0] lw_reg;
    logic [IDX_W-1:0]       p_reg, n_reg, tail_reg;
    logic                   neg_reg;

    logic [TID_W-1:0]       o_pt_reg;
    logic                   o_pv_reg, o_nr_reg, m_valid_reg;
    logic [SLICE_W-1:0]     o_so_reg;
    logic [STATUS_W-1:0]    o_st_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    wrrs_div #(.N_BITS(DIV_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp)
    );

    logic               acc;
    logic               tid_ok;
    logic [TOT_W:0]     tot_sum;
    logic [TOT_W-1:0]   tot_add, tot_sat;
    logic [SLICE_W-1:0] dec_slc, new_slc;
    logic [DIV_W-1:0]   w_ext;

    assign acc    = s_valid && s_ready;
    assign tid_ok = (32'(s_task_id) < 32'(MAX_TASKS));
    assign w_ext  = DIV_W'(w_reg);
    assign dec_slc = slc_reg - 1'b1;
    assign new_slc = slice_of(neg_reg, drsp.quo);

    assign tot_sum = {1'b0, total_reg} + (TOT_W + 1)'(w_reg);
    assign tot_add = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
    assign tot_sat = (tot_add > TOT_W'(lw_reg)) ? tot_add - TOT_W'(lw_reg) : '0;

    assign s_ready   = (state_reg == S_IDLE) && !m_valid_reg;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        if (state_reg == S_SLICE && (func_reg == FUNC_ENQ || tick_exp_reg) &&
            count_reg != '0) begin
            dreq.start = 1'b1;
            dreq.num   = 64'(total_reg);
            dreq.den   = 64'(count_reg);
        end else if (state_reg == S_DIV1 && drsp.done && w_reg != '0 &&
                     drsp.quo != '0) begin
            dreq.start = 1'b1;
            if (drsp.quo[DIV_W-1:0] > w_ext) begin
                dreq.num = drsp.quo;
                dreq.den = 64'(w_ext);
            end else begin
                dreq.num = 64'(w_ext);
                dreq.den = drsp.quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            inq_reg     <= '0;
            head_reg    <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            smin_reg    <= 4'd1;
            smax_reg    <= 4'd10;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SLICE_MIN) smin_reg <= cfg_data;
                else                            smax_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        func_reg <= s_func;
                        tid_reg  <= (s_func == FUNC_PICK) ? head_reg : IDX_W'(s_task_id);
                        w_reg    <= WEIGHT_BITS'(s_weight[W_USE-1:0]);
                        ath_reg  <= s_at_head;
                        o_pt_reg <= '0;
                        o_pv_reg <= 1'b0;
                        o_so_reg <= '0;
                        o_nr_reg <= 1'b0;
                        o_st_reg <= ST_OK;
                        tick_exp_reg <= 1'b0;
                        if (s_func == FUNC_PICK) begin
                            state_reg <= S_READ;
                        end else if (s_func > FUNC_PICK || !tid_ok) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    slc_reg  <= slc_mem[tid_reg];
                    lw_reg   <= lw_mem[tid_reg];
                    p_reg    <= prv_mem[tid_reg];
                    n_reg    <= nxt_mem[tid_reg];
                    tail_reg <= prv_mem[head_reg];
                    state_reg <= S_UNLINK;
                end
                S_UNLINK: begin
                    unique case (func_reg)
                        FUNC_PICK: begin
                            relink_reg <= 1'b0;
                            if (count_reg == '0) begin
                                o_st_reg <= ST_EMPTY;
                            end else begin
                                o_pt_reg <= TID_W'(head_reg);
                                o_pv_reg <= 1'b1;
                                o_so_reg <= slc_reg;
                            end
                            state_reg <= S_OUT;
                        end
                        FUNC_ENQ: begin
                            total_reg <= tot_add;
                            lw_reg    <= w_reg;
                            relink_reg <= 1'b1;
                            state_reg  <= S_LINK;
                        end
                        FUNC_DEQ: begin
                            total_reg <= (total_reg > TOT_W'(w_reg)) ?
                                         total_reg - TOT_W'(w_reg) : '0;
                            relink_reg <= 1'b0;
                            state_reg  <= S_LINK;
                        end
                        FUNC_YIELD: begin
                            relink_reg <= inq_reg[tid_reg];
                            state_reg  <= S_LINK;
                        end
                        FUNC_TICK: begin
                            slc_reg <= dec_slc;
                            relink_reg <= (dec_slc == '0) && inq_reg[tid_reg] &&
                                          count_reg >= CNT_W'(2);
                            state_reg <= S_LINK;
                            if (dec_slc == '0) begin
                                tick_exp_reg <= 1'b1;
                                if (lw_reg != w_reg) begin
                                    total_reg <= tot_sat;
                                    lw_reg    <= w_reg;
                                end
                            end
                        end
                        default: begin
                            relink_reg <= 1'b0;
                            state_reg  <= S_OUT;
                        end
                    endcase
                    // Unlink for enqueue, dequeue and relinks.
                    if (inq_reg[tid_reg] && (func_reg == FUNC_ENQ || func_reg == FUNC_DEQ ||
                        func_reg == FUNC_YIELD ||
                        (func_reg == FUNC_TICK && dec_slc == '0 && count_reg >= CNT_W'(2)))) begin
                        if (count_reg > CNT_W'(1)) begin
                            nxt_mem[p_reg] <= n_reg;
                            prv_mem[n_reg] <= p_reg;
                            if (head_reg == tid_reg) head_reg <= n_reg;
                            if (tail_reg == tid_reg) tail_reg <= p_reg;
                        end
                        inq_reg[tid_reg] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                S_LINK: begin
                    if (relink_reg) begin
                        if (count_reg == '0) begin
                            nxt_mem[tid_reg] <= tid_reg;
                            prv_mem[tid_reg] <= tid_reg;
                            head_reg <= tid_reg;
                        end else begin
                            nxt_mem[tail_reg] <= tid_reg;
                            prv_mem[tid_reg]  <= tail_reg;
                            nxt_mem[tid_reg]  <= head_reg;
                            prv_mem[head_reg] <= tid_reg;
                            if (func_reg == FUNC_ENQ && ath_reg) head_reg <= tid_reg;
                        end
                        inq_reg[tid_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        o_nr_reg <= (func_reg == FUNC_TICK);
                    end
                    if (func_reg == FUNC_ENQ || func_reg == FUNC_TICK)
                        lw_mem[tid_reg] <= lw_reg;
                    if (func_reg == FUNC_ENQ || tick_exp_reg) begin
                        // Score uses the count after relinking.
                        state_reg <= S_SLICE;
                    end else begin
                        state_reg <= S_OUT;
                        if (func_reg == FUNC_TICK) slc_mem[tid_reg] <= slc_reg;
                        o_so_reg <= (func_reg == FUNC_TICK) ? slc_reg : slc_mem[tid_reg];
                    end
                end
                S_SLICE: begin
                    // Count settled; start the average division unless the queue is empty.
                    if (count_reg == '0) begin
                        slc_reg   <= 4'd5;
                        state_reg <= S_DIV2;
                        neg_reg   <= 1'b0;
                    end else begin
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (drsp.done) begin
                        neg_reg <= drsp.quo[DIV_W-1:0] > w_ext;
                        if (w_reg == '0) begin
                            slc_reg   <= 4'd10;
                            state_reg <= S_DIV2;
                        end else if (drsp.quo == '0) begin
                            slc_reg   <= 4'd5;
                            state_reg <= S_DIV2;
                        end else begin
                            slc_reg   <= '1;
                            state_reg <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    if (slc_reg != '1 || drsp.done) begin
                        logic [SLICE_W-1:0] s;
                        s = (slc_reg != '1) ? slc_reg : new_slc;
                        state_reg <= S_OUT;
                        if (func_reg == FUNC_ENQ && (s < smin_reg || s > smax_reg)) begin
                            o_st_reg <= ST_RANGE;
                            o_so_reg <= slc_mem[tid_reg];
                        end else begin
                            slc_mem[tid_reg] <= s;
                            o_so_reg <= s;
                        end
                    end
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_picked_task  = o_pt_reg;
    assign m_picked_valid = o_pv_reg;
    assign m_slice_out    = o_so_reg;
    assign m_need_resched = o_nr_reg;
    assign m_status       = o_st_reg;

endmodule

// ----- rtl/wrrs_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wrrs_pkg.
`timescale 1ns / 1ps

module wrrs_div #(
    parameter int N_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wrrs_pkg::div_req_t req,
    output wrrs_pkg::div_rsp_t rsp
);
    import wrrs_pkg::*;

    localparam int CNT_W = $clog2(N_BITS + 1);

    logic [N_BITS-1:0] den_reg, quo_reg;
    logic [N_BITS:0]   rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [N_BITS:0]   trial;

    assign trial = {rem_reg[N_BITS-1:0], quo_reg[N_BITS-1]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_BITS);
                rem_reg  <= '0;
                quo_reg  <= req.num[N_BITS-1:0];
                den_reg  <= req.den[N_BITS-1:0];
            end else if (busy_reg) begin
                if (trial[N_BITS]) begin
                    rem_reg <= {rem_reg[N_BITS-1:0], quo_reg[N_BITS-1]};
                    quo_reg <= {quo_reg[N_BITS-2:0], 1'b0};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[N_BITS-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = 64'(quo_reg);

endmodule

// ----- rtl/wrrs_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
// Depends on weight_ratio_round_robin_scheduler_top.
`timescale 1ns / 1ps

module wrrs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_picked_valid,
    input logic       m_need_resched,
    input logic [1:0] m_status
);
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request accepted while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_pick_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_picked_valid |-> m_status == 2'd0 && !m_need_resched)
        else $error("pick result inconsistent");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3) else $error("bad status");
endmodule

bind weight_ratio_round_robin_scheduler_top wrrs_checker u_chk (.*);
